>>> rtl/sacf_pkg.sv
package sacf_pkg;

    typedef enum logic [1:0] {
        FN_READ   = 2'd0,
        FN_WRITE  = 2'd1,
        FN_INSERT = 2'd2,
        FN_REMOVE = 2'd3
    } t_func;

    typedef struct packed {
        logic clr;
        logic load;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_sts;

endpackage

>>> rtl/sacf_ram.sv
module sacf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sacf_ctrl.sv
module sacf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sacf_pkg::t_cmd o_cmd,
    input  sacf_pkg::t_sts i_sts
);
    import sacf_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_in_ready;

    assign w_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd      = '0;
        o_cmd.clr  = (r_state == S_CLEAR);
        o_cmd.load = w_in_ready && i_in_valid;
        o_cmd.exec = (r_state == S_EXEC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid && w_in_ready) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && w_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted item did not reach exec");
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> r_out_valid)
        else $error("exec did not raise result valid");
    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !r_out_valid)
        else $error("result register busy at exec");
`endif

endmodule

>>> rtl/sacf_dp.sv
module sacf_dp #(
    parameter int WAYS        = 4,
    parameter int ROWS        = 128,
    parameter int OFFSET_BITS = 6,
    parameter int ADDR_BITS   = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sacf_pkg::t_cmd i_cmd,
    output sacf_pkg::t_sts o_sts,
    input  logic [1:0]     i_func,
    input  logic [31:0]    i_address,
    output logic           o_found,
    output logic [1:0]     o_way,
    output logic           o_dirty
);
    import sacf_pkg::*;

    localparam int IDX_W = $clog2(ROWS);
    localparam int TAG_W = ADDR_BITS - OFFSET_BITS - IDX_W;
    localparam int WB    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * (2 + TAG_W + WB);

    typedef struct packed {
        logic [WAYS-1:0][WB-1:0]    order;
        logic [WAYS-1:0][TAG_W-1:0] tags;
        logic [WAYS-1:0]            dirty;
        logic [WAYS-1:0]            valid;
    } t_row;

    logic [IDX_W-1:0] w_idx;
    logic [IDX_W-1:0] w_row_in;
    logic [TAG_W-1:0] w_tag_in;

    t_func            r_func;
    logic [TAG_W-1:0] r_tag;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_clr_addr;
    logic             r_found;
    logic [1:0]       r_way;
    logic             r_dirty;

    logic [ROW_W-1:0] w_rdata;
    t_row             w_cur;
    t_row             w_new;
    t_row             w_rst_row;
    logic             w_hit;
    logic [WB-1:0]    w_hw;
    logic [WB-1:0]    w_pos;
    logic [WB-1:0]    w_head;
    logic             n_found;
    logic [1:0]       n_way;
    logic             n_dirty;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [ROW_W-1:0] w_wdata;

    // address split, row index folded once when rows is not a power of two
    assign w_idx    = i_address[OFFSET_BITS +: IDX_W];
    assign w_tag_in = i_address[ADDR_BITS-1 : OFFSET_BITS + IDX_W];
    assign w_row_in = ({1'b0, w_idx} >= (IDX_W+1)'(ROWS))
                    ? IDX_W'({1'b0, w_idx} - (IDX_W+1)'(ROWS)) : w_idx;

    assign o_sts.clr_done = (r_clr_addr == IDX_W'(ROWS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr && !o_sts.clr_done) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= t_func'(i_func);
            r_tag  <= w_tag_in;
            r_row  <= w_row_in;
        end
        if (i_cmd.exec) begin
            r_found <= n_found;
            r_way   <= n_way;
            r_dirty <= n_dirty;
        end
    end

    always_comb begin
        w_rst_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            w_rst_row.order[w] = WB'(w);
        end
    end

    assign w_cur = t_row'(w_rdata);

    always_comb begin
        w_hit = 1'b0;
        w_hw  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_cur.valid[w] && (w_cur.tags[w] == r_tag)) begin
                w_hit = 1'b1;
                w_hw  = WB'(w);
            end
        end
        w_pos = WB'(WAYS - 1);
        for (int p = WAYS - 1; p >= 0; p--) begin
            if (w_cur.order[p] == w_hw) begin
                w_pos = WB'(p);
            end
        end
    end

    assign w_head = w_cur.order[0];

    always_comb begin
        w_new   = w_cur;
        n_found = 1'b0;
        n_way   = 2'd0;
        n_dirty = 1'b0;
        case (r_func)
            FN_INSERT: begin
                w_new.valid[w_head] = 1'b1;
                w_new.dirty[w_head] = 1'b0;
                w_new.tags[w_head]  = r_tag;
                for (int p = 0; p < WAYS - 1; p++) begin
                    w_new.order[p] = w_cur.order[p+1];
                end
                w_new.order[WAYS-1] = w_head;
                n_found = 1'b1;
                n_way   = 2'(w_head);
            end
            FN_WRITE: begin
                if (w_hit) begin
                    w_new.dirty[w_hw] = 1'b1;
                    n_found = 1'b1;
                    n_way   = 2'(w_hw);
                    n_dirty = 1'b1;
                end
            end
            FN_REMOVE: begin
                if (w_hit) begin
                    for (int q = 1; q < WAYS; q++) begin
                        if (WB'(q) <= w_pos) begin
                            w_new.order[q] = w_cur.order[q-1];
                        end
                    end
                    w_new.order[0]    = w_hw;
                    w_new.valid[w_hw] = 1'b0;
                    n_found = 1'b1;
                    n_way   = 2'(w_hw);
                    n_dirty = w_cur.dirty[w_hw];
                end
            end
            default: begin
                if (w_hit) begin
                    n_found = 1'b1;
                    n_way   = 2'(w_hw);
                    n_dirty = w_cur.dirty[w_hw];
                end
            end
        endcase
    end

    assign w_we    = i_cmd.clr || i_cmd.exec;
    assign w_waddr = i_cmd.clr ? r_clr_addr : r_row;
    assign w_wdata = i_cmd.clr ? ROW_W'(w_rst_row) : ROW_W'(w_new);

    sacf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (w_row_in),
        .o_rdata (w_rdata)
    );

    assign o_found = r_found;
    assign o_way   = r_way;
    assign o_dirty = r_dirty;

`ifndef SYNTHESIS
    a_insert_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_cmd.exec) && ($past(r_func) == FN_INSERT)) |-> r_found)
        else $error("insert result not found");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_cmd.exec) && !r_found) |-> ((r_way == 2'd0) && !r_dirty))
        else $error("miss result carries way or dirty");
    a_write_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_cmd.exec) && ($past(r_func) == FN_WRITE) && r_found) |-> r_dirty)
        else $error("write hit not dirty");
`endif

endmodule

>>> rtl/set_assoc_cache_fifo_replace.sv
// set-associative cache tag store with per-row fifo replacement
// input channel: i_valid / o_ready carrying i_func and i_address
//   func read, write (marks dirty on hit), insert (fills fifo head way), remove
// output channel: o_valid / i_ready carrying o_found, o_way, o_dirty
//   exactly one result item per input item, in order
// each item does one read-modify-write of its row in a simple dual-port row ram:
//   ram read on accept, update and write back in the next cycle
// result: an accepted item passes through the exec state, then waits in the output register
// one item at a time: the next item is accepted only after the row read-modify-write
//   of the last has finished; reset: a clearing pass writes every row, with o_ready low
// stall: a waiting result sits in the output register; the next item is
//   accepted only once that register is free or is being taken
module set_assoc_cache_fifo_replace #(
    parameter int WAYS        = 4,
    parameter int ROWS        = 128,
    parameter int OFFSET_BITS = 6,
    parameter int ADDR_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [1:0]  o_way,
    output logic        o_dirty
);
    import sacf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sacf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    sacf_dp #(
        .WAYS        (WAYS),
        .ROWS        (ROWS),
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_func    (i_func),
        .i_address (i_address),
        .o_found   (o_found),
        .o_way     (o_way),
        .o_dirty   (o_dirty)
    );

endmodule
